@@ design/pht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pht_pkg;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_ENTRY_COUNT = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CENTRE_X    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CENTRE_Y    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_MIN_HALF    = 3'd3;

    localparam logic [15:0] MIN_HALF_RESET = 16'd96;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_DISC    = 2'd1;
    localparam logic [1:0] KIND_ANNULUS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } state_t;

    // One table entry as it sits in the memory word.
    typedef struct packed {
        logic [15:0] disc_x;
        logic [15:0] disc_y;
        logic [15:0] disc_radius;
        logic [15:0] ring_inner;
        logic [15:0] ring_outer;
    } entry_t;

    // Verdict on one entry at the end of the evaluation pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic disc_hit;
        logic band_hit;
    } eval_t;

endpackage

`default_nettype wire

@@ design/pht_table_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pht_table_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire pht_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output pht_pkg::entry_t      rdata
);
    import pht_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/pht_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pht_eval #(
    parameter int AW = 6
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            flush,
    input  wire logic            ent_valid,
    input  wire logic            ent_last,
    input  wire logic [AW-1:0]   ent_idx,
    input  wire pht_pkg::entry_t ent,
    input  wire logic [15:0]     px,
    input  wire logic [15:0]     py,
    input  wire logic [15:0]     cx,
    input  wire logic [15:0]     cy,
    input  wire logic [15:0]     min_half,
    output pht_pkg::eval_t       verdict,
    output logic [AW-1:0]        verdict_idx
);
    import pht_pkg::*;

    // Squared distance from the point to the annulus centre. The point and
    // centre hold still during a walk, so this settles before the first entry
    // reaches the last stage.
    logic signed [16:0] cdx_reg, cdy_reg;
    logic [32:0]        cdx_sq_reg, cdy_sq_reg;
    logic [33:0]        d2c_reg;
    logic signed [33:0] cdx_prod, cdy_prod;

    assign cdx_prod = 34'(cdx_reg) * 34'(cdx_reg);
    assign cdy_prod = 34'(cdy_reg) * 34'(cdy_reg);

    always_ff @(posedge clk)
    begin
        cdx_reg    <= $signed({px[15], px}) - $signed({cx[15], cx});
        cdy_reg    <= $signed({py[15], py}) - $signed({cy[15], cy});
        cdx_sq_reg <= cdx_prod[32:0];
        cdy_sq_reg <= cdy_prod[32:0];
        d2c_reg    <= {1'b0, cdx_sq_reg} + {1'b0, cdy_sq_reg};
    end

    // Stage 2: differences, band midpoint and floored half-width.
    logic               v2_reg, last2_reg, disc_en2_reg, band_en2_reg;
    logic [AW-1:0]      idx2_reg;
    logic signed [16:0] dx2_reg, dy2_reg;
    logic [15:0]        r2_reg;
    logic signed [15:0] mid2_reg;
    logic signed [16:0] half2_reg;

    logic signed [16:0] band_sum, band_diff, half_raw, floor_x, half_next;

    always_comb
    begin
        band_sum  = $signed({ent.ring_inner[15], ent.ring_inner})
                  + $signed({ent.ring_outer[15], ent.ring_outer});
        band_diff = $signed({ent.ring_outer[15], ent.ring_outer})
                  - $signed({ent.ring_inner[15], ent.ring_inner});
        half_raw  = $signed({band_diff[16], band_diff[16:1]});
        floor_x   = $signed({1'b0, min_half});
        half_next = (half_raw < floor_x) ? floor_x : half_raw;
    end

    always_ff @(posedge clk)
    begin
        dx2_reg      <= $signed({px[15], px}) - $signed({ent.disc_x[15], ent.disc_x});
        dy2_reg      <= $signed({py[15], py}) - $signed({ent.disc_y[15], ent.disc_y});
        r2_reg       <= ent.disc_radius;
        disc_en2_reg <= (ent.disc_radius != 16'd0);
        band_en2_reg <= !ent.ring_outer[15] && (ent.ring_outer != 16'd0);
        mid2_reg     <= $signed(band_sum[16:1]);
        half2_reg    <= half_next;
        idx2_reg     <= ent_idx;
        last2_reg    <= ent_last;
    end

    // Stage 3: squares for the disc, bounds of the band.
    logic               v3_reg, last3_reg, disc_en3_reg, band_en3_reg;
    logic [AW-1:0]      idx3_reg;
    logic [32:0]        dx_sq3_reg, dy_sq3_reg;
    logic [31:0]        rr3_reg;
    logic signed [17:0] lo3_reg, hi3_reg;
    logic signed [33:0] dx_prod, dy_prod;
    logic signed [17:0] mid_x, half_x;

    assign dx_prod = 34'(dx2_reg) * 34'(dx2_reg);
    assign dy_prod = 34'(dy2_reg) * 34'(dy2_reg);
    assign mid_x   = $signed({{2{mid2_reg[15]}}, mid2_reg});
    assign half_x  = $signed({half2_reg[16], half2_reg});

    always_ff @(posedge clk)
    begin
        dx_sq3_reg   <= dx_prod[32:0];
        dy_sq3_reg   <= dy_prod[32:0];
        rr3_reg      <= 32'(r2_reg) * 32'(r2_reg);
        lo3_reg      <= mid_x - half_x;
        hi3_reg      <= mid_x + half_x;
        disc_en3_reg <= disc_en2_reg;
        band_en3_reg <= band_en2_reg;
        idx3_reg     <= idx2_reg;
        last3_reg    <= last2_reg;
    end

    // Stage 4: disc compare, squares of the band bounds.
    logic               v4_reg, last4_reg, disc_hit4_reg, band_en4_reg;
    logic [AW-1:0]      idx4_reg;
    logic [33:0]        lo_sq4_reg, hi_sq4_reg;
    logic signed [35:0] lo_prod, hi_prod;
    logic [33:0]        disc_d2;

    assign lo_prod = 36'(lo3_reg) * 36'(lo3_reg);
    assign hi_prod = 36'(hi3_reg) * 36'(hi3_reg);
    assign disc_d2 = {1'b0, dx_sq3_reg} + {1'b0, dy_sq3_reg};

    always_ff @(posedge clk)
    begin
        disc_hit4_reg <= disc_en3_reg && (disc_d2 <= {2'b00, rr3_reg});
        lo_sq4_reg    <= lo_prod[33:0];
        hi_sq4_reg    <= hi_prod[33:0];
        band_en4_reg  <= band_en3_reg;
        idx4_reg      <= idx3_reg;
        last4_reg     <= last3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= ent_valid && !flush;
            v3_reg <= v2_reg && !flush;
            v4_reg <= v3_reg && !flush;
        end
    end

    always_comb
    begin
        verdict.valid    = v4_reg;
        verdict.last     = last4_reg;
        verdict.disc_hit = disc_hit4_reg;
        verdict.band_hit = band_en4_reg && (d2c_reg >= lo_sq4_reg)
                           && (d2c_reg <= hi_sq4_reg);
        verdict_idx      = idx4_reg;
    end

endmodule

`default_nettype wire

@@ design/point_hit_test_disc_annulus.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Point hit test against a table of discs and annuli. A write word (cmd 0)
// stores one entry. A query word (cmd 1) walks the entries
// from slot 0 upward, one read a cycle from the table memory
// through a four-stage evaluation pipeline, and delivers one result word.
// The walk covers n = min(entry_count, MAX_ENTRIES) entries; a disc hit
// ends it early, and n = 0 skips it. The result sits in an output
// register, so the next word is taken while it waits to be read. The
// configuration registers may be written only while no query is in flight.
module point_hit_test_disc_annulus #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [pht_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [pht_pkg::CFG_DW-1:0]   cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         cmd,
    input  wire logic [5:0]                   entry_index,
    input  wire logic signed [15:0]           entry_x,
    input  wire logic signed [15:0]           entry_y,
    input  wire logic [15:0]                  disc_radius,
    input  wire logic signed [15:0]           ring_inner,
    input  wire logic signed [15:0]           ring_outer,
    input  wire logic signed [15:0]           point_x,
    input  wire logic signed [15:0]           point_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        hit_kind,
    output logic [5:0]                        hit_index
);
    import pht_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Configuration registers.
    logic [6:0]  entry_count_reg;
    logic [15:0] centre_x_reg, centre_y_reg, min_half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 7'd0;
            centre_x_reg    <= 16'd0;
            centre_y_reg    <= 16'd0;
            min_half_reg    <= MIN_HALF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENTRY_COUNT: entry_count_reg <= cfg_wdata[6:0];
                REG_CENTRE_X:    centre_x_reg    <= cfg_wdata;
                REG_CENTRE_Y:    centre_y_reg    <= cfg_wdata;
                REG_MIN_HALF:    min_half_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    logic [CW-1:0] n_lim;

    always_comb
    begin
        if (32'(entry_count_reg) > MAX_ENTRIES)
        begin
            n_lim = CW'(MAX_ENTRIES);
        end
        else
        begin
            n_lim = CW'(entry_count_reg);
        end
    end

    // Control.
    state_t state_reg, state_next;
    logic   issue, finish, load_out, accept;
    logic   slot_ok, mem_we;

    eval_t         ev;
    logic [AW-1:0] ev_idx;

    logic [CW-1:0] rd_cnt_reg;
    logic          v1_reg, last1_reg;
    logic [AW-1:0] idx1_reg;
    logic          band_found_reg;
    logic [AW-1:0] band_idx_reg;
    logic [1:0]    res_kind_reg, res_kind_next;
    logic [AW-1:0] res_idx_reg, res_idx_next;
    logic [15:0]   px_reg, py_reg;
    logic          out_valid_reg;
    logic [1:0]    hit_kind_reg;
    logic [5:0]    hit_index_reg;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (cmd == CMD_QUERY))
                begin
                    state_next = (n_lim == '0) ? ST_RESULT : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (finish)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        finish   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_WALK:
            begin
                issue  = (rd_cnt_reg < n_lim);
                finish = ev.valid && (ev.disc_hit || ev.last);
            end
            ST_RESULT: load_out = !out_valid_reg || out_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Writes happen only while idle and reads only while walking, so the two
    // never touch the table in the same cycle.
    assign slot_ok = (32'(entry_index) < MAX_ENTRIES);
    assign mem_we  = accept && (cmd == CMD_WRITE) && slot_ok;

    logic [AW+5:0] waddr_ext;
    entry_t        wentry, rentry;

    assign waddr_ext = {{AW{1'b0}}, entry_index};

    always_comb
    begin
        wentry.disc_x      = entry_x;
        wentry.disc_y      = entry_y;
        wentry.disc_radius = disc_radius;
        wentry.ring_inner  = ring_inner;
        wentry.ring_outer  = ring_outer;
    end

    pht_table_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr_ext[AW-1:0]),
        .wdata (wentry),
        .re    (issue),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (rentry)
    );

    logic [CW:0] rd_cnt_inc;
    assign rd_cnt_inc = {1'b0, rd_cnt_reg} + (CW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg     <= '0;
            v1_reg         <= 1'b0;
            band_found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue && !finish;
            if (accept)
            begin
                rd_cnt_reg     <= '0;
                band_found_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_inc[CW-1:0];
                end
                if ((state_reg == ST_WALK) && ev.valid && !ev.disc_hit && ev.band_hit)
                begin
                    band_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= rd_cnt_reg[AW-1:0];
        last1_reg <= (rd_cnt_inc == {1'b0, n_lim});
        if (accept && (cmd == CMD_QUERY))
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        if ((state_reg == ST_WALK) && ev.valid && ev.band_hit && !band_found_reg)
        begin
            band_idx_reg <= ev_idx;
        end
    end

    pht_eval #(
        .AW (AW)
    ) u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .flush       (finish),
        .ent_valid   (v1_reg),
        .ent_last    (last1_reg),
        .ent_idx     (idx1_reg),
        .ent         (rentry),
        .px          (px_reg),
        .py          (py_reg),
        .cx          (centre_x_reg),
        .cy          (centre_y_reg),
        .min_half    (min_half_reg),
        .verdict     (ev),
        .verdict_idx (ev_idx)
    );

    // The first disc hit wins; otherwise the earliest band hit, which may be
    // the entry being judged right now.
    always_comb
    begin
        res_kind_next = res_kind_reg;
        res_idx_next  = res_idx_reg;
        if (accept && (cmd == CMD_QUERY))
        begin
            res_kind_next = KIND_NONE;
            res_idx_next  = '0;
        end
        else if (finish)
        begin
            if (ev.disc_hit)
            begin
                res_kind_next = KIND_DISC;
                res_idx_next  = ev_idx;
            end
            else if (band_found_reg)
            begin
                res_kind_next = KIND_ANNULUS;
                res_idx_next  = band_idx_reg;
            end
            else if (ev.band_hit)
            begin
                res_kind_next = KIND_ANNULUS;
                res_idx_next  = ev_idx;
            end
            else
            begin
                res_kind_next = KIND_NONE;
                res_idx_next  = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_kind_reg <= res_kind_next;
        res_idx_reg  <= res_idx_next;
    end

    logic [AW+5:0] res_idx_ext;
    assign res_idx_ext = {6'd0, res_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            hit_kind_reg  <= res_kind_reg;
            hit_index_reg <= res_idx_ext[5:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_kind  = hit_kind_reg;
    assign hit_index = hit_index_reg;

endmodule

`default_nettype wire

@@ design/pht_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pht_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       cmd,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] hit_kind,
    input wire logic [5:0] hit_index
);
    import pht_pkg::*;

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_kind) && $stable(hit_index))
        else $error("result word changed while stalled");

    // A miss always reports slot zero.
    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit_kind == KIND_NONE) |-> (hit_index == 6'd0))
        else $error("miss with nonzero slot");

    // A table write never produces a result word.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_WRITE) && !out_valid |=> !out_valid)
        else $error("result word after a table write");

    // The block is not ready for a new word in the cycle after it takes a query.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_QUERY) |=> !in_ready)
        else $error("new word taken right after a query");

endmodule

bind point_hit_test_disc_annulus pht_checker u_pht_checker (.*);

`default_nettype wire
